// ===== src/rvalu_pkg.sv =====
// ----------------------------------------------------------------------------
// RISC-V integer ALU execute package
// Shared widths, encodings and interface structs of the execute block.
// ----------------------------------------------------------------------------
package rvalu_pkg;

   localparam int XLEN      = 64;
   localparam int NUM_REGS  = 32;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int INSTR_W   = 32;
   localparam int SHAMT_W   = (XLEN > 32) ? 6 : 5;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [11:0] SHAMT_MASK12 = 12'((1 << SHAMT_W) - 1);
   localparam logic [11:0] ALT_MASK12   = 12'h400;

   typedef enum logic [2:0] {
      F3_ADD_SUB = 3'd0,
      F3_SLL     = 3'd1,
      F3_SLT     = 3'd2,
      F3_SLTU    = 3'd3,
      F3_XOR     = 3'd4,
      F3_SRL_SRA = 3'd5,
      F3_OR      = 3'd6,
      F3_AND     = 3'd7
   } funct3_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]      data;
   } reg_write_type;

   typedef struct packed {
      logic            wrote;
      logic            illegal;
      logic [XLEN-1:0] value;
   } alu_result_type;

endpackage

// ===== src/rvalu_regfile.sv =====
// ----------------------------------------------------------------------------
// Register file memory
// Two registered read ports and one write port, with per-entry valid bits so
// that entries not yet written read as zero after reset.
// ----------------------------------------------------------------------------
module rvalu_regfile (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      rd_en,
   input  logic [rvalu_pkg::REG_IDX_W-1:0]           rd_addr_a,
   input  logic [rvalu_pkg::REG_IDX_W-1:0]           rd_addr_b,
   output logic [rvalu_pkg::XLEN-1:0]                rd_data_a,
   output logic [rvalu_pkg::XLEN-1:0]                rd_data_b,
   input  rvalu_pkg::reg_write_type                  wr
);

   logic [rvalu_pkg::XLEN-1:0]     mem_ff [rvalu_pkg::NUM_REGS];
   logic [rvalu_pkg::NUM_REGS-1:0] valid_ff;
   logic [rvalu_pkg::XLEN-1:0]     data_a_ff;
   logic [rvalu_pkg::XLEN-1:0]     data_b_ff;
   logic                           vld_a_ff;
   logic                           vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= mem_ff[rd_addr_a];
         data_b_ff <= mem_ff[rd_addr_b];
         vld_a_ff  <= valid_ff[rd_addr_a];
         vld_b_ff  <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : '0;
   assign rd_data_b = vld_b_ff ? data_b_ff : '0;

endmodule

// ===== src/rvalu_alu.sv =====
// ----------------------------------------------------------------------------
// Decode and ALU
// Decodes OP and OP-IMM instructions and computes the destination value.
// ----------------------------------------------------------------------------
module rvalu_alu (
   input  logic [rvalu_pkg::INSTR_W-1:0] instr,
   input  logic [rvalu_pkg::XLEN-1:0]    op_a,
   input  logic [rvalu_pkg::XLEN-1:0]    op_b,
   output rvalu_pkg::alu_result_type     result
);

   logic [6:0]                        opc;
   logic [rvalu_pkg::REG_IDX_W-1:0]   rd;
   rvalu_pkg::funct3_type             f3;
   logic [6:0]                        f7;
   logic [11:0]                       imm12;
   logic [rvalu_pkg::XLEN-1:0]        imm_sext;
   logic [rvalu_pkg::XLEN-1:0]        b;
   logic [rvalu_pkg::SHAMT_W-1:0]     sh;
   logic                              alt;
   logic                              legal;
   logic                              illegal;
   logic [rvalu_pkg::XLEN-1:0]        sra_res;
   logic [rvalu_pkg::XLEN-1:0]        res;

   assign opc      = instr[6:0];
   assign rd       = instr[11:7];
   assign f3       = rvalu_pkg::funct3_type'(instr[14:12]);
   assign f7       = instr[31:25];
   assign imm12    = instr[31:20];
   assign imm_sext = {{(rvalu_pkg::XLEN-12){imm12[11]}}, imm12};
   assign sra_res  = $signed(op_a) >>> sh;

   always_comb begin
      legal   = 1'b0;
      alt     = 1'b0;
      illegal = 1'b0;
      b       = op_b;
      sh      = op_b[rvalu_pkg::SHAMT_W-1:0];
      case (opc)
         rvalu_pkg::OPC_OP: begin
            alt   = f7[5];
            legal = (f7 == rvalu_pkg::F7_BASE) ||
                    ((f7 == rvalu_pkg::F7_ALT) &&
                     (f3 inside {rvalu_pkg::F3_ADD_SUB, rvalu_pkg::F3_SRL_SRA}));
         end
         rvalu_pkg::OPC_OP_IMM: begin
            b  = imm_sext;
            sh = imm12[rvalu_pkg::SHAMT_W-1:0];
            case (f3)
               rvalu_pkg::F3_SLL: begin
                  legal = (imm12 & ~rvalu_pkg::SHAMT_MASK12) == 12'd0;
               end
               rvalu_pkg::F3_SRL_SRA: begin
                  alt   = imm12[10];
                  legal = (imm12 & ~rvalu_pkg::SHAMT_MASK12 & ~rvalu_pkg::ALT_MASK12)
                          == 12'd0;
               end
               default: begin
                  legal = 1'b1;
               end
            endcase
         end
         rvalu_pkg::OPC_LOAD, rvalu_pkg::OPC_STORE, rvalu_pkg::OPC_BRANCH: begin
            legal = 1'b0;
         end
         default: begin
            illegal = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (f3)
         rvalu_pkg::F3_ADD_SUB: res = alt ? (op_a - b) : (op_a + b);
         rvalu_pkg::F3_SLL:     res = op_a << sh;
         rvalu_pkg::F3_SLT: begin
            res = {{(rvalu_pkg::XLEN-1){1'b0}}, ($signed(op_a) < $signed(b))};
         end
         rvalu_pkg::F3_SLTU:    res = {{(rvalu_pkg::XLEN-1){1'b0}}, (op_a < b)};
         rvalu_pkg::F3_XOR:     res = op_a ^ b;
         rvalu_pkg::F3_SRL_SRA: res = alt ? sra_res : (op_a >> sh);
         rvalu_pkg::F3_OR:      res = op_a | b;
         default:               res = op_a & b;
      endcase
   end

   assign result.wrote   = legal && (rd != '0);
   assign result.illegal = illegal;
   assign result.value   = result.wrote ? res : '0;

endmodule

// ===== src/rv_integer_alu_execute.sv =====
// ----------------------------------------------------------------------------
// RISC-V integer ALU execute block
// Each request item carries one 32-bit instruction word. OP and OP-IMM
// instructions read two registers, compute a result and write it back to the
// register file; each item yields exactly one response item with the
// destination index, the value written, a write flag and an illegal flag.
// The register file memory is read in the acceptance cycle, the ALU works in
// the following cycle and the result is written back as it moves into the
// output register, so one item is taken every cycle while the receiver does
// not stall. A result written in the same cycle as the next item's read is
// forwarded to that item. Reset clears all control state; the register file
// reads as zero until an entry is written. While the receiver stalls, the
// response holds and the ALU stage keeps its item; the request side stalls
// only when that stage is full and cannot move on.
// ----------------------------------------------------------------------------
module rv_integer_alu_execute (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rvalu_pkg::INSTR_W-1:0]       req_instr_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rvalu_pkg::REG_IDX_W-1:0]     rsp_dest_index,
   output logic [rvalu_pkg::XLEN-1:0]          rsp_dest_value,
   output logic                                rsp_wrote_register,
   output logic                                rsp_illegal_opcode
);

   logic                              accept_in;
   logic                              advance;
   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   logic [rvalu_pkg::INSTR_W-1:0]     s1_instr_ff;
   rvalu_pkg::reg_write_type          fwd_ff;
   rvalu_pkg::reg_write_type          fwd_in;
   rvalu_pkg::reg_write_type          wr;
   rvalu_pkg::alu_result_type         alu_res;
   logic [rvalu_pkg::XLEN-1:0]        rd_data_a;
   logic [rvalu_pkg::XLEN-1:0]        rd_data_b;
   logic [rvalu_pkg::XLEN-1:0]        op_a;
   logic [rvalu_pkg::XLEN-1:0]        op_b;
   logic [rvalu_pkg::REG_IDX_W-1:0]   s1_rs1;
   logic [rvalu_pkg::REG_IDX_W-1:0]   s1_rs2;
   logic [rvalu_pkg::REG_IDX_W-1:0]   s1_rd;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [rvalu_pkg::REG_IDX_W-1:0]   rsp_index_ff;
   logic [rvalu_pkg::XLEN-1:0]        rsp_value_ff;
   logic                              rsp_wrote_ff;
   logic                              rsp_illegal_ff;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept_in = req_valid && !req_stall;

   assign s1_rs1 = s1_instr_ff[19:15];
   assign s1_rs2 = s1_instr_ff[24:20];
   assign s1_rd  = s1_instr_ff[11:7];

   rvalu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept_in),
      .rd_addr_a (req_instr_word[19:15]),
      .rd_addr_b (req_instr_word[24:20]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr        (wr)
   );

   assign op_a = (fwd_ff.en && (fwd_ff.idx == s1_rs1)) ? fwd_ff.data : rd_data_a;
   assign op_b = (fwd_ff.en && (fwd_ff.idx == s1_rs2)) ? fwd_ff.data : rd_data_b;

   rvalu_alu u_alu (
      .instr  (s1_instr_ff),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (alu_res)
   );

   assign wr.en   = advance && alu_res.wrote;
   assign wr.idx  = s1_rd;
   assign wr.data = alu_res.value;

   always_comb begin
      fwd_in = fwd_ff;
      if (accept_in) begin
         fwd_in = wr;
      end
   end

   assign s1_valid_in  = accept_in || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_instr_ff <= req_instr_word;
      end
      if (advance) begin
         rsp_index_ff   <= s1_rd;
         rsp_value_ff   <= alu_res.value;
         rsp_wrote_ff   <= alu_res.wrote;
         rsp_illegal_ff <= alu_res.illegal;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dest_index     = rsp_index_ff;
   assign rsp_dest_value     = rsp_value_ff;
   assign rsp_wrote_register = rsp_wrote_ff;
   assign rsp_illegal_opcode = rsp_illegal_ff;

endmodule

// ===== src/rvalu_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the RISC-V integer ALU execute block
// Watches the top-level ports and checks response consistency over time.
// ----------------------------------------------------------------------------
module rvalu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [rvalu_pkg::REG_IDX_W-1:0]     rsp_dest_index,
   input logic [rvalu_pkg::XLEN-1:0]          rsp_dest_value,
   input logic                                rsp_wrote_register,
   input logic                                rsp_illegal_opcode
);

   // A write to register zero is never reported.
   a_no_write_x0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wrote_register) |-> (rsp_dest_index != '0))
      else $error("response reports a write to register zero");

   // An item that writes nothing carries a zero value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_wrote_register) |-> (rsp_dest_value == '0))
      else $error("response without write carries a nonzero value");

   // An illegal instruction never writes the register file.
   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_illegal_opcode) |-> !rsp_wrote_register)
      else $error("illegal instruction reported a register write");

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_dest_index) &&
         $stable(rsp_dest_value) && $stable(rsp_wrote_register) &&
         $stable(rsp_illegal_opcode)))
      else $error("stalled response item changed");

   // No response item can appear in the first cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rv_integer_alu_execute rvalu_checker u_rvalu_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_dest_index     (rsp_dest_index),
   .rsp_dest_value     (rsp_dest_value),
   .rsp_wrote_register (rsp_wrote_register),
   .rsp_illegal_opcode (rsp_illegal_opcode)
);
